/* sv/fifo_weighted_admission_limiter_assert.svh */
// assertion macros for the weighted admission limiter
`ifndef FIFO_WEIGHTED_ADMISSION_LIMITER_ASSERT_SVH
`define FIFO_WEIGHTED_ADMISSION_LIMITER_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define FWAL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwal assertion failed");
// antecedent implies consequent in the next cycle
`define FWAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwal assertion failed");
// condition never holds
`define FWAL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fwal assertion failed");
`else
`define FWAL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FWAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define FWAL_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* sv/fwal_pkg.sv */
// shared types and constants of the weighted admission limiter
`default_nettype none

package fwal_pkg;

    localparam int AMOUNT_BITS = 40;
    localparam int ID_BITS     = 4;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        EV_GRANTED  = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_RELEASED = 3'd2,
        EV_NOTHING  = 3'd3,
        EV_ERROR    = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        KIND_ACQUIRE,
        KIND_RELEASE,
        KIND_BAD_ID
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_GRANT
    } t_state;

    // input beat
    typedef struct packed {
        t_op                    op;
        logic [ID_BITS-1:0]     waiter_id;
        logic [AMOUNT_BITS-1:0] request_size;
    } t_cmd;

    // result beat
    typedef struct packed {
        t_event                 event_res;
        logic [ID_BITS-1:0]     subject_id;
        logic [AMOUNT_BITS-1:0] amount;
        logic [AMOUNT_BITS-1:0] total_in_use;
        logic                   last;
    } t_res;

    // classified request as held between front and back
    typedef struct packed {
        t_kind                  kind;
        logic [ID_BITS-1:0]     waiter_id;
        logic [AMOUNT_BITS-1:0] request_size;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_chan;

endpackage

`default_nettype wire

/* sv/fwal_front.sv */
// front end: takes command beats, classifies them and buffers them for the back end
`default_nettype none

module fwal_front
    import fwal_pkg::*;
#(
    parameter int WAITERS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_cmd      i_cmd,
    output t_job_chan      o_chan,
    input  wire logic      i_pop
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    t_job       cls_job;

    assign busy = (r_cnt == 2'd2);
    assign push = start & ~busy;

    // classify the incoming beat
    always_comb begin
        cls_job.waiter_id    = i_cmd.waiter_id;
        cls_job.request_size = i_cmd.request_size;
        if (32'(i_cmd.waiter_id) >= WAITERS) begin
            cls_job.kind = KIND_BAD_ID;
        end else if (i_cmd.op == OP_ACQUIRE) begin
            cls_job.kind = KIND_ACQUIRE;
        end else begin
            cls_job.kind = KIND_RELEASE;
        end
    end

    // two-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cls_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_chan.valid = (r_cnt != 2'd0);
    assign o_chan.job   = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

/* sv/fwal_back.sv */
// back end: holds the budget, holdings and wait ring and produces result beats
`default_nettype none

`include "fifo_weighted_admission_limiter_assert.svh"

module fwal_back
    import fwal_pkg::*;
#(
    parameter int WAITERS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [AMOUNT_BITS-1:0] i_cfg_data,
    input  wire t_job_chan              i_chan,
    output logic                        o_pop,
    output logic                        o_res_strobe,
    output t_res                        o_res
);

    localparam int QW = $clog2(WAITERS);
    localparam int CW = $clog2(WAITERS + 1);
    localparam int SW = CW + 1;

    t_state                 r_state, n_state;
    logic [AMOUNT_BITS-1:0] r_cap;
    logic [AMOUNT_BITS-1:0] r_total, n_total;
    logic [QW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [WAITERS-1:0]     r_waiting, n_waiting;
    logic [WAITERS-1:0]     r_holds, n_holds;
    logic [QW-1:0]          r_wait_q [WAITERS];
    logic [AMOUNT_BITS-1:0] r_held [WAITERS];
    logic [AMOUNT_BITS-1:0] r_rd_a;
    logic [AMOUNT_BITS-1:0] r_rd_b;
    t_job                   r_job;
    t_res                   r_pend, n_pend;
    t_res                   r_res, n_res;
    logic                   r_res_vld, n_res_vld;

    logic                   mem_we;
    logic [QW-1:0]          mem_waddr;
    logic [AMOUNT_BITS-1:0] mem_wdata;
    logic                   q_we;
    logic [QW-1:0]          q_waddr;
    logic [QW-1:0]          job_idx;
    logic [QW-1:0]          head_w;
    logic [QW-1:0]          tail;
    logic [SW-1:0]          tail_sum;
    logic                   rel_ok;
    logic                   chk_more;

    function automatic logic fn_fits(
        input logic [AMOUNT_BITS-1:0] size,
        input logic [AMOUNT_BITS-1:0] total,
        input logic [AMOUNT_BITS-1:0] cap
    );
        logic ok;
        if (total == '0) begin
            ok = 1'b1;
        end else if (total > cap) begin
            ok = 1'b0;
        end else begin
            ok = (size <= cap - total);
        end
        return ok;
    endfunction

    assign job_idx  = QW'(r_job.waiter_id);
    assign head_w   = r_wait_q[r_head];
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(WAITERS)) ? QW'(tail_sum - SW'(WAITERS))
                                                 : QW'(tail_sum);
    assign rel_ok   = (r_job.kind == KIND_RELEASE) && !r_waiting[job_idx] && r_holds[job_idx];
    assign chk_more = (r_count != '0) && fn_fits(r_rd_b, r_total, r_cap);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_chan.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = rel_ok ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                n_state = chk_more ? ST_GRANT : ST_IDLE;
            end
            ST_GRANT: begin
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state updates and result beats
    always_comb begin
        n_total   = r_total;
        n_head    = r_head;
        n_count   = r_count;
        n_waiting = r_waiting;
        n_holds   = r_holds;
        n_pend    = r_pend;
        n_res     = r_res;
        n_res_vld = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = job_idx;
        mem_wdata = r_job.request_size;
        q_we      = 1'b0;
        q_waddr   = tail;
        o_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_chan.valid;
            end
            ST_EXEC: begin
                n_res.event_res    = EV_ERROR;
                n_res.subject_id   = r_job.waiter_id;
                n_res.amount       = '0;
                n_res.total_in_use = r_total;
                n_res.last         = 1'b1;
                case (r_job.kind)
                    KIND_ACQUIRE: begin
                        n_res_vld = 1'b1;
                        if (r_waiting[job_idx] || r_holds[job_idx]) begin
                            n_res.event_res = EV_ERROR;
                        end else if (fn_fits(r_job.request_size, r_total, r_cap)) begin
                            mem_we             = 1'b1;
                            n_holds[job_idx]   = |r_job.request_size;
                            n_total            = r_total + r_job.request_size;
                            n_res.event_res    = EV_GRANTED;
                            n_res.amount       = r_job.request_size;
                            n_res.total_in_use = n_total;
                        end else if (r_count == CW'(WAITERS)) begin
                            n_res.event_res = EV_ERROR;
                        end else begin
                            mem_we             = 1'b1;
                            q_we               = 1'b1;
                            n_count            = r_count + CW'(1);
                            n_waiting[job_idx] = 1'b1;
                            n_holds[job_idx]   = |r_job.request_size;
                            n_res.event_res    = EV_QUEUED;
                            n_res.amount       = r_job.request_size;
                        end
                    end
                    KIND_RELEASE: begin
                        if (r_waiting[job_idx]) begin
                            n_res_vld       = 1'b1;
                            n_res.event_res = EV_ERROR;
                        end else if (!r_holds[job_idx]) begin
                            n_res_vld       = 1'b1;
                            n_res.event_res = EV_NOTHING;
                        end else begin
                            // freed amount goes out after the head check
                            n_total           = (r_rd_a > r_total) ? '0 : r_total - r_rd_a;
                            n_holds[job_idx]  = 1'b0;
                            n_pend.event_res  = EV_RELEASED;
                            n_pend.subject_id = r_job.waiter_id;
                            n_pend.amount     = r_rd_a;
                        end
                    end
                    default: begin
                        n_res_vld       = 1'b1;
                        n_res.event_res = EV_ERROR;
                    end
                endcase
            end
            ST_CHECK: begin
                n_res_vld          = 1'b1;
                n_res              = r_pend;
                n_res.total_in_use = r_total;
                n_res.last         = ~chk_more;
            end
            ST_GRANT: begin
                // head fits: take it off the ring
                n_total           = r_total + r_rd_b;
                n_waiting[head_w] = 1'b0;
                n_head            = (r_head == QW'(WAITERS - 1)) ? '0 : r_head + QW'(1);
                n_count           = r_count - CW'(1);
                n_pend.event_res  = EV_GRANTED;
                n_pend.subject_id = ID_BITS'(head_w);
                n_pend.amount     = r_rd_b;
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    // holdings memory, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_held[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_held[QW'(i_chan.job.waiter_id)];
        r_rd_b <= r_held[r_wait_q[n_head]];
    end

    // wait ring of waiter slots
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_wait_q[q_waddr] <= job_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_chan.job;
        end
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cap     <= '1;
            r_total   <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_waiting <= '0;
            r_holds   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_head    <= n_head;
            r_count   <= n_count;
            r_waiting <= n_waiting;
            r_holds   <= n_holds;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    assign o_res_strobe = r_res_vld;
    assign o_res        = r_res;

    // checks
    `FWAL_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(WAITERS))
    `FWAL_ASSERT_IMPLY(a_empty_no_wait, i_clk, i_rst_n, r_count == '0, r_waiting == '0)
    `FWAL_ASSERT_IMPLY(a_more_follows, i_clk, i_rst_n, r_res_vld && !r_res.last, r_state == ST_GRANT)
    `FWAL_ASSERT_NEXT(a_pop_exec, i_clk, i_rst_n, o_pop, r_state == ST_EXEC)

endmodule

`default_nettype wire

/* sv/fifo_weighted_admission_limiter.sv */
// top level of the weighted admission limiter
//
// Usage: a command beat (op, waiter_id, request_size) is taken on i_cmd at a
// clock edge with start high and busy low. Acquires are granted when the
// running total plus the size fits the capacity (or nothing is reserved),
// otherwise queued in arrival order. A release frees the holding and then
// grants queued heads in order while they fit.
// Results leave on o_res, each valid for exactly one cycle while o_res_strobe
// is high; o_res.last marks the final beat of a command. The receiver cannot
// stall. Capacity is written through i_cfg_we / i_cfg_data while idle.
// Flow: the front buffers up to two commands; the back takes one at a time.
// An acquire, an error or an empty release passes the back through its idle
// and exec states. A release passes idle, exec and check, plus a grant and
// a check state per queued grant (one read of the holdings memory and one
// fit check each); the releasing waiter is never queued, so at most WAITERS - 1
// grants follow, for up to WAITERS result beats.
// A synchronous reset clears the budget, holdings, wait flags and ring pointers;
// capacity returns to all ones.
`default_nettype none

module fifo_weighted_admission_limiter
    import fwal_pkg::*;
#(
    parameter int WAITERS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire t_cmd                   i_cmd,
    input  wire logic                   i_cfg_we,
    input  wire logic [AMOUNT_BITS-1:0] i_cfg_data,
    output logic                        o_res_strobe,
    output t_res                        o_res
);

    t_job_chan chan;
    logic      pop;

    // command intake and classification
    fwal_front #(
        .WAITERS (WAITERS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_chan  (chan),
        .i_pop   (pop)
    );

    // budget bookkeeping and result beats
    fwal_back #(
        .WAITERS (WAITERS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_chan       (chan),
        .o_pop        (pop),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// testbench for the weighted admission limiter: queued command driver, result monitor
module tb_top;
    import fwal_pkg::*;

    localparam int WAITERS = 16;

    typedef struct {
        t_cmd        cmd;
        int unsigned gap;
    } cmd_slot_t;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   start        = 1'b0;
    t_cmd                   i_cmd        = '0;
    logic                   i_cfg_we     = 1'b0;
    logic [AMOUNT_BITS-1:0] i_cfg_data   = '0;
    logic                   busy;
    logic                   o_res_strobe;
    t_res                   o_res;

    // command beats waiting to be driven, result beats still due
    cmd_slot_t cmd_backlog[$];
    t_res      outcome_q[$];
    int        mismatch_count = 0;
    int        gap_count      = 0;
    bit        burst_mode     = 1'b0;
    bit        claimed[WAITERS];

    // shadow of the admission state
    logic [AMOUNT_BITS-1:0] budget         = '1;
    logic [AMOUNT_BITS-1:0] reserved_total = '0;
    logic [AMOUNT_BITS-1:0] holding[WAITERS];
    bit                     queued_flag[WAITERS];
    logic [ID_BITS-1:0]     line_ring[WAITERS];
    int                     line_head      = 0;
    int                     line_count     = 0;

    fifo_weighted_admission_limiter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    always #10 i_clk = ~i_clk;

    // fit test, safe against overflow of total plus size
    function automatic bit room_for(logic [AMOUNT_BITS-1:0] sz);
        if (reserved_total == '0) return 1'b1;
        if (reserved_total > budget) return 1'b0;
        return sz <= budget - reserved_total;
    endfunction

    function automatic void note_outcome(t_event ev, logic [ID_BITS-1:0] id,
                                         logic [AMOUNT_BITS-1:0] amt);
        t_res r;
        r.event_res    = ev;
        r.subject_id   = id;
        r.amount       = amt;
        r.total_in_use = reserved_total;
        r.last         = 1'b0;
        outcome_q.push_back(r);
    endfunction

    // work out the result beats of one accepted command
    function automatic void admit_cmd(t_cmd c);
        int                     id;
        int                     w;
        logic [AMOUNT_BITS-1:0] need;
        t_res                   tail_res;
        id = c.waiter_id;
        if (c.op == OP_ACQUIRE) begin
            if (queued_flag[id] || holding[id] != '0) begin
                note_outcome(EV_ERROR, c.waiter_id, '0);
            end else if (room_for(c.request_size)) begin
                holding[id]    = c.request_size;
                reserved_total = reserved_total + c.request_size;
                note_outcome(EV_GRANTED, c.waiter_id, c.request_size);
            end else if (line_count >= WAITERS) begin
                note_outcome(EV_ERROR, c.waiter_id, '0);
            end else begin
                line_ring[(line_head + line_count) % WAITERS] = c.waiter_id;
                line_count      = line_count + 1;
                holding[id]     = c.request_size;
                queued_flag[id] = 1'b1;
                note_outcome(EV_QUEUED, c.waiter_id, c.request_size);
            end
        end else begin
            if (queued_flag[id]) begin
                note_outcome(EV_ERROR, c.waiter_id, '0);
            end else if (holding[id] == '0) begin
                note_outcome(EV_NOTHING, c.waiter_id, '0);
            end else begin
                need = holding[id];
                reserved_total = (need > reserved_total) ? '0 : reserved_total - need;
                holding[id] = '0;
                note_outcome(EV_RELEASED, c.waiter_id, need);
                // hand out to queued heads while they fit
                while (line_count > 0) begin
                    w    = line_ring[line_head];
                    need = holding[w];
                    if (!room_for(need)) break;
                    line_head      = (line_head + 1) % WAITERS;
                    line_count     = line_count - 1;
                    reserved_total = reserved_total + need;
                    queued_flag[w] = 1'b0;
                    note_outcome(EV_GRANTED, ID_BITS'(w), need);
                end
            end
        end
        tail_res = outcome_q.pop_back();
        tail_res.last = 1'b1;
        outcome_q.push_back(tail_res);
    endfunction

    // driver: one command beat at a time, gap drawn per beat
    always @(posedge i_clk) begin
        cmd_slot_t nxt;
        if (!i_rst_n) begin
            start     <= 1'b0;
            gap_count <= 0;
        end else begin
            if (start && !busy) admit_cmd(i_cmd);
            if (!start || !busy) begin
                if (cmd_backlog.size() != 0 && gap_count >= cmd_backlog[0].gap) begin
                    nxt = cmd_backlog.pop_front();
                    i_cmd     <= nxt.cmd;
                    start     <= 1'b1;
                    gap_count <= 0;
                end else begin
                    start <= 1'b0;
                    if (cmd_backlog.size() != 0) gap_count <= gap_count + 1;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest one due
    always @(posedge i_clk) begin
        t_res due;
        if (i_rst_n && o_res_strobe) begin
            if (outcome_q.size() == 0) begin
                $error("result beat with none due: subject_id %0d", o_res.subject_id);
                mismatch_count = mismatch_count + 1;
            end else begin
                due = outcome_q.pop_front();
                if (o_res.event_res !== due.event_res) begin
                    $error("event_res expected %0d actual %0d", due.event_res, o_res.event_res);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_res.subject_id !== due.subject_id) begin
                    $error("subject_id expected %0d actual %0d",
                           due.subject_id, o_res.subject_id);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_res.amount !== due.amount) begin
                    $error("amount expected %0d actual %0d", due.amount, o_res.amount);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_res.total_in_use !== due.total_in_use) begin
                    $error("total_in_use expected %0d actual %0d",
                           due.total_in_use, o_res.total_in_use);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_res.last !== due.last) begin
                    $error("last expected %0d actual %0d", due.last, o_res.last);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    task automatic queue_cmd(input t_op op, input int id, input logic [AMOUNT_BITS-1:0] sz);
        cmd_slot_t s;
        s.cmd.op           = op;
        s.cmd.waiter_id    = ID_BITS'(id);
        s.cmd.request_size = sz;
        if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
        s.gap = burst_mode ? 0 : $urandom_range(0, 18);
        cmd_backlog.push_back(s);
    endtask

    // wait for every beat to be taken and answered, then let the pipe drain
    // (checked mid-cycle so the driver's updates of the edge are settled)
    task automatic settle();
        while (cmd_backlog.size() != 0 || start || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_budget(input logic [AMOUNT_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        budget = v;
    endtask

    // size mostly up to about half the budget, with the extremes mixed in
    function automatic logic [AMOUNT_BITS-1:0] draw_size(logic [AMOUNT_BITS-1:0] cap);
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return wide[AMOUNT_BITS-1:0];
            default: return AMOUNT_BITS'(wide % ({24'd0, cap} / 2 + 64'd2));
        endcase
    endfunction

    // acquire from free slots, release slots we acquired, some noise
    task automatic random_phase(input logic [AMOUNT_BITS-1:0] cap, input int n);
        int   free_ids[$];
        int   held_ids[$];
        int   id;
        int   roll;
        logic [63:0] wide;
        set_budget(cap);
        repeat (n) begin
            free_ids.delete();
            held_ids.delete();
            for (int i = 0; i < WAITERS; i++) begin
                if (claimed[i]) held_ids.push_back(i);
                else free_ids.push_back(i);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                wide = {$urandom, $urandom};
                queue_cmd(t_op'($urandom_range(0, 1)), $urandom_range(0, WAITERS - 1),
                          wide[AMOUNT_BITS-1:0]);
            end else if ((roll < 55 && free_ids.size() != 0) || held_ids.size() == 0) begin
                id = free_ids[$urandom_range(0, free_ids.size() - 1)];
                claimed[id] = 1'b1;
                queue_cmd(OP_ACQUIRE, id, draw_size(cap));
            end else begin
                id = held_ids[$urandom_range(0, held_ids.size() - 1)];
                claimed[id] = 1'b0;
                queue_cmd(OP_RELEASE, id, draw_size(cap));
            end
        end
        settle();
    endtask

    initial begin
        logic [31:0] lo;
        for (int i = 0; i < WAITERS; i++) begin
            holding[i]     = '0;
            queued_flag[i] = 1'b0;
            line_ring[i]   = '0;
            claimed[i]     = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small budget: grants, queueing, errors, empty release, ordered hand-out
        set_budget(40'd100);
        queue_cmd(OP_ACQUIRE, 0, 40'd60);
        queue_cmd(OP_ACQUIRE, 1, 40'd50);
        queue_cmd(OP_ACQUIRE, 1, 40'd7);     // second acquire while queued
        queue_cmd(OP_ACQUIRE, 0, 40'd5);     // second acquire while holding
        queue_cmd(OP_RELEASE, 1, '0);        // release while queued
        queue_cmd(OP_RELEASE, 5, '1);        // nothing held
        queue_cmd(OP_ACQUIRE, 2, '0);        // zero-size grant
        queue_cmd(OP_RELEASE, 2, '0);        // zero-size grant counts as nothing held
        queue_cmd(OP_ACQUIRE, 3, 40'd40);
        queue_cmd(OP_ACQUIRE, 4, 40'd30);
        queue_cmd(OP_ACQUIRE, 5, 40'd1);
        queue_cmd(OP_RELEASE, 0, '0);        // grants one head, stops at the next
        queue_cmd(OP_RELEASE, 3, '0);        // grants two heads
        queue_cmd(OP_ACQUIRE, 15, '1);       // oversized, queued behind holders
        queue_cmd(OP_RELEASE, 1, '0);
        queue_cmd(OP_RELEASE, 4, '0);
        queue_cmd(OP_RELEASE, 5, '0);        // total drops to zero, oversized runs alone
        queue_cmd(OP_RELEASE, 15, '0);
        settle();

        // full budget: fit test near the top of the range
        set_budget('1);
        queue_cmd(OP_ACQUIRE, 0, '1);
        queue_cmd(OP_ACQUIRE, 1, '1);
        queue_cmd(OP_ACQUIRE, 2, '0);
        queue_cmd(OP_RELEASE, 0, '0);
        queue_cmd(OP_RELEASE, 1, '0);
        settle();

        // zero budget: only a request while nothing is reserved gets through
        set_budget('0);
        queue_cmd(OP_ACQUIRE, 3, 40'd5);
        queue_cmd(OP_ACQUIRE, 4, '0);
        queue_cmd(OP_RELEASE, 3, '0);
        queue_cmd(OP_RELEASE, 4, '0);
        settle();

        // random traffic across several budgets
        random_phase(40'd1, 75);
        random_phase(AMOUNT_BITS'($urandom_range(2, 1000)), 75);
        lo = $urandom;
        random_phase({8'($urandom_range(0, 255)), lo} | 40'd1, 75);
        random_phase('1, 75);
        random_phase(40'd100, 75);
        random_phase(AMOUNT_BITS'($urandom_range(2, 300)), 75);

        if (mismatch_count == 0) begin
            $display("[fifo_weighted_admission_limiter] OK");
        end else begin
            $display("[fifo_weighted_admission_limiter] ERROR");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #5000000;
        $display("[fifo_weighted_admission_limiter] ERROR");
        $finish;
    end

endmodule
